FILE: rtl/vzs_pkg.sv
// ----------------------------------------------------------------------------
// vzs_pkg
// shared types and codes for the varint / zigzag byte serializer
// ----------------------------------------------------------------------------
package vzs_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 3;

	// format codes
	typedef enum logic [OP_W-1:0] {
		OP_FIXED8   = 3'd0,
		OP_FIXED16  = 3'd1,
		OP_FIXED32  = 3'd2,
		OP_FIXED64  = 3'd3,
		OP_VARINT32 = 3'd4,
		OP_VARINT64 = 3'd5,
		OP_ZIGZAG32 = 3'd6,
		OP_ZIGZAG64 = 3'd7
	} op_t;

	// how the shift register is drained
	typedef enum logic [1:0] {
		KIND_FIXED_LE = 2'd0,
		KIND_FIXED_BE = 2'd1,
		KIND_VARINT   = 2'd2
	} kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	localparam logic [BYTE_W-1:0] CONT_BIT = 8'h80;

endpackage

FILE: rtl/varint_zigzag_serializer.sv
// ----------------------------------------------------------------------------
// varint_zigzag_serializer
// turns one value and a format code into its serialized byte stream
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  -------------------------
// input     in         in_valid / in_ready    operation, value
// output    out        out_valid / out_ready  out_byte, last
// config    in         cfg_wr_en              cfg_wr_data (big_endian)
//
// an item is loaded, then emitted byte by byte (fixed formats 1/2/4/8 bytes,
// varints 1 to 10 bytes) by the single byte shifter that drains the working
// register one byte a cycle while the output is not stalled.
// reset clears the sequencer and output valid and sets big_endian to 1.
// a stalled output holds the current byte and freezes the shifter; the input
// side is ready only while the sequencer is idle.
//
module varint_zigzag_serializer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [vzs_pkg::OP_W-1:0]    operation,
	input  logic [vzs_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [vzs_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_wr_data
);
	import vzs_pkg::*;

	state_t              state_q;
	kind_t               kind_q;
	logic [VALUE_W-1:0]  shift_q;    // working value, drained by the shifter
	logic [CNT_W-1:0]    cnt_q;      // fixed formats: bytes left minus one
	logic                big_endian_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                last_q;

	// load path
	logic                in_fire;
	op_t                 op;
	logic [VALUE_W-1:0]  load_val;
	kind_t               load_kind;
	logic [CNT_W-1:0]    load_cnt;
	logic [31:0]         lo32;

	// shared shift unit and byte former
	logic                out_free;
	logic                step;
	logic                more;
	logic [BYTE_W-1:0]   next_byte;
	logic                next_last;
	logic [VALUE_W-1:0]  next_shift;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign op        = op_t'(operation);
	assign lo32      = value[31:0];

	// format decode: zigzag map, masking and left alignment for big endian
	always_comb begin
		load_val  = value;
		load_kind = KIND_VARINT;
		load_cnt  = '0;
		unique case (op)
			OP_FIXED8: begin
				load_kind = big_endian_q ? KIND_FIXED_BE : KIND_FIXED_LE;
				load_cnt  = CNT_W'(0);
				load_val  = big_endian_q ? {value[7:0], 56'd0} : value;
			end
			OP_FIXED16: begin
				load_kind = big_endian_q ? KIND_FIXED_BE : KIND_FIXED_LE;
				load_cnt  = CNT_W'(1);
				load_val  = big_endian_q ? {value[15:0], 48'd0} : value;
			end
			OP_FIXED32: begin
				load_kind = big_endian_q ? KIND_FIXED_BE : KIND_FIXED_LE;
				load_cnt  = CNT_W'(3);
				load_val  = big_endian_q ? {value[31:0], 32'd0} : value;
			end
			OP_FIXED64: begin
				load_kind = big_endian_q ? KIND_FIXED_BE : KIND_FIXED_LE;
				load_cnt  = CNT_W'(7);
				load_val  = value;
			end
			OP_VARINT32: load_val = {32'd0, lo32};
			OP_VARINT64: load_val = value;
			// (v << 1) ^ sign fill, 32-bit result zero extended
			OP_ZIGZAG32: load_val = {32'd0, {lo32[30:0], 1'b0} ^ {32{lo32[31]}}};
			OP_ZIGZAG64: load_val = {value[62:0], 1'b0} ^ {VALUE_W{value[63]}};
			default:     load_val = value;
		endcase
	end

	// one byte per step: 7-bit group with continuation for varints,
	// top or bottom byte for fixed formats
	assign more = |shift_q[VALUE_W-1:7];

	always_comb begin
		next_byte  = shift_q[7:0];
		next_last  = (cnt_q == '0);
		next_shift = shift_q >> BYTE_W;
		case (kind_q)
			KIND_FIXED_BE: begin
				next_byte  = shift_q[VALUE_W-1 -: BYTE_W];
				next_shift = shift_q << BYTE_W;
			end
			KIND_VARINT: begin
				next_byte  = more ? (CONT_BIT | {1'b0, shift_q[6:0]})
				                  : {1'b0, shift_q[6:0]};
				next_last  = !more;
				next_shift = shift_q >> 7;
			end
			default: begin
				next_byte  = shift_q[7:0];
				next_shift = shift_q >> BYTE_W;
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign step     = (state_q == ST_EMIT) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_EMIT;
				ST_EMIT: if (step && next_last) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working register and byte counter
	always_ff @(posedge clk) begin
		if (in_fire) begin
			shift_q <= load_val;
			kind_q  <= load_kind;
			cnt_q   <= load_cnt;
		end else if (step) begin
			shift_q <= next_shift;
			cnt_q   <= cnt_q - CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= next_byte;
			last_q     <= next_last;
		end
	end

	// byte order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (cfg_wr_en) begin
			big_endian_q <= cfg_wr_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule
